[design/msat_pkg.sv]
// Shared types and constants for the multi-session alarm timer.
`default_nettype none

package msat_pkg;

   // Request function codes.
   localparam logic [2:0] FN_TICK     = 3'd0;
   localparam logic [2:0] FN_ONCE     = 3'd1;
   localparam logic [2:0] FN_PERIODIC = 3'd2;
   localparam logic [2:0] FN_READ_US  = 3'd3;
   localparam logic [2:0] FN_READ_MS  = 3'd4;
   localparam logic [2:0] FN_OPEN     = 3'd5;

   // Result kinds.
   localparam logic [1:0] KIND_FIRE = 2'd0;
   localparam logic [1:0] KIND_US   = 2'd1;
   localparam logic [1:0] KIND_MS   = 2'd2;

   // Configuration register indexes.
   localparam logic [1:0] CSR_CLUSTER  = 2'd0;
   localparam logic [1:0] CSR_MIN_ONCE = 2'd1;
   localparam logic [1:0] CSR_MIN_PER  = 2'd2;

   // Reset values of the configuration registers.
   localparam logic [15:0] CLUSTER_RESET  = 16'd250;
   localparam logic [15:0] MIN_ONCE_RESET = 16'd250;
   localparam logic [19:0] MIN_PER_RESET  = 20'd1000;

   // Microseconds per millisecond and the remainder width of the divider.
   localparam int          REM_W  = 10;
   localparam logic [REM_W:0] US_PER_MS = 11'd1000;

   // Digit width of the millisecond divider and the reciprocal of one
   // thousand scaled by two to the MS_SHIFT, exact for any remainder-digit pair.
   localparam int              MS_DIG_W    = 16;
   localparam int              MS_RECIP_W  = 27;
   localparam logic [26:0]     MS_RECIP    = 27'd68719477;
   localparam int              MS_SHIFT    = 36;

   localparam logic [63:0] TIME_INFINITE = 64'hFFFF_FFFF_FFFF_FFFF;

   // Per-session state carried through the ring.
   typedef struct packed {
      logic        armed;
      logic [63:0] atime;
      logic [63:0] period;
      logic [63:0] open;
   } entry_type;

   // Modification applied to one entry as it passes the head of the ring.
   typedef enum logic [2:0] {
      OP_NONE,
      OP_ONCE,
      OP_PERIODIC,
      OP_OPEN,
      OP_FIRE
   } op_type;

   // What a ring pass gathers.
   typedef enum logic [1:0] {
      MODE_SOON,
      MODE_RES,
      MODE_DUE,
      MODE_READ
   } mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PER_OUT,
      ST_PASS,
      ST_POST,
      ST_FLUSH,
      ST_DIV
   } state_type;

endpackage

`default_nettype wire

[design/msat_cell.sv]
// One ring cell holding the state of one session.
`default_nettype none

module msat_cell #(
   parameter int SID_W    = 3,
   parameter int INIT_SID = 0
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     shift,
   input  wire msat_pkg::entry_type in_entry,
   input  wire  [SID_W-1:0]        in_sid,
   output msat_pkg::entry_type     q_entry,
   output logic [SID_W-1:0]        q_sid
);

   msat_pkg::entry_type entry_ff;
   logic [SID_W-1:0]    sid_ff;

   // Take the neighbor's contents on every shift.
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
         sid_ff   <= SID_W'(INIT_SID);
      end else if (shift) begin
         entry_ff <= in_entry;
         sid_ff   <= in_sid;
      end
   end

   assign q_entry = entry_ff;
   assign q_sid   = sid_ff;

endmodule

`default_nettype wire

[design/msat_div.sv]
// Divider by one thousand for millisecond reads, one 16-bit digit per cycle.
`default_nettype none

module msat_div (
   input  wire         clock,
   input  wire         reset,
   input  wire         start,
   input  wire  [63:0] dividend,
   output logic        done,
   output logic [63:0] quotient
);

   localparam int DIG_W  = msat_pkg::MS_DIG_W;
   localparam int PART_W = msat_pkg::REM_W + DIG_W;
   localparam int PROD_W = PART_W + msat_pkg::MS_RECIP_W;

   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic [1:0]                 cnt_ff, cnt_in;
   logic [63:0]                num_ff, num_in;
   logic [msat_pkg::REM_W-1:0] rem_ff, rem_in;
   logic [PART_W-1:0]          part;
   logic [PROD_W-1:0]          prod;
   logic [DIG_W-1:0]           qdig;
   logic [PART_W-1:0]          back;

   // Long division by digits: the remainder and the next dividend digit are
   // divided by reciprocal multiplication, the quotient digit shifts in.
   always_comb begin
      busy_in = busy_ff;
      done_in = done_ff;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      part    = {rem_ff, num_ff[63 -: DIG_W]};
      prod    = PROD_W'(part) * PROD_W'(msat_pkg::MS_RECIP);
      qdig    = prod[msat_pkg::MS_SHIFT +: DIG_W];
      back    = part - PART_W'(qdig) * PART_W'(msat_pkg::US_PER_MS);
      if (start) begin
         busy_in = 1'b1;
         done_in = 1'b0;
         cnt_in  = '0;
         num_in  = dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         rem_in = back[msat_pkg::REM_W-1:0];
         num_in = {num_ff[63-DIG_W:0], qdig};
         cnt_in = cnt_ff + 2'd1;
         if (cnt_ff == 2'd3) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
         num_ff  <= '0;
         rem_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
         num_ff  <= num_in;
         rem_ff  <= rem_in;
      end
   end

   assign done     = done_ff;
   assign quotient = num_ff;

endmodule

`default_nettype wire

[design/multi_session_alarm_timer.sv]
// Top level of the multi-session alarm timer.
`default_nettype none

// The session state sits in a ring of SESSIONS cells that rotates by one
// cell per cycle during a pass; each pass brings every session past the
// head once, where it is updated and compared, and each pass is followed by
// a decision state. An arm or open takes two passes (update with soonest
// search, then cluster deadline), or one pass less when no alarm is left
// armed; a periodic arm first gives its immediate fire. A microsecond read
// takes one pass, and a millisecond read adds the divider. A tick before
// the deadline runs no pass; a firing tick takes one pass per fire, one
// more pass that finds nothing further due unless the fire limit is hit,
// a flush step and the deadline passes, plus any wait on the result
// channel. One request is worked on at a time.
module multi_session_alarm_timer #(
   parameter int SESSIONS  = 8,
   parameter int MAX_FIRES = 64
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_stall,
   input  wire  [2:0]  req_func,
   input  wire  [2:0]  req_session,
   input  wire  [63:0] req_value_us,
   input  wire  [63:0] req_now_us,
   output logic        rsp_valid,
   input  wire         rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [2:0]  rsp_session_res,
   output logic [63:0] rsp_value,
   output logic        rsp_last,
   input  wire         csr_we,
   input  wire  [1:0]  csr_index,
   input  wire  [19:0] csr_wdata
);

   localparam int SID_W = (SESSIONS > 1) ? $clog2(SESSIONS) : 1;
   localparam int N_W   = $clog2(MAX_FIRES + 1);

   // Configuration registers.
   logic [15:0] cluster_ff, min_once_ff;
   logic [19:0] min_per_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cluster_ff  <= msat_pkg::CLUSTER_RESET;
         min_once_ff <= msat_pkg::MIN_ONCE_RESET;
         min_per_ff  <= msat_pkg::MIN_PER_RESET;
      end else if (csr_we) begin
         case (csr_index)
            msat_pkg::CSR_CLUSTER:  cluster_ff  <= csr_wdata[15:0];
            msat_pkg::CSR_MIN_ONCE: min_once_ff <= csr_wdata[15:0];
            msat_pkg::CSR_MIN_PER:  min_per_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Ring of session cells.
   msat_pkg::entry_type ent_q [SESSIONS];
   logic [SID_W-1:0]    sid_q [SESSIONS];
   msat_pkg::entry_type head_mod;
   logic                shift;

   for (genvar k = 0; k < SESSIONS; k++) begin : g_cell
      if (k == SESSIONS - 1) begin : g_tail
         msat_cell #(.SID_W(SID_W), .INIT_SID(k)) u_cell (
            .clock(clock), .reset(reset), .shift(shift),
            .in_entry(head_mod), .in_sid(sid_q[0]),
            .q_entry(ent_q[k]), .q_sid(sid_q[k]));
      end else begin : g_body
         msat_cell #(.SID_W(SID_W), .INIT_SID(k)) u_cell (
            .clock(clock), .reset(reset), .shift(shift),
            .in_entry(ent_q[k+1]), .in_sid(sid_q[k+1]),
            .q_entry(ent_q[k]), .q_sid(sid_q[k]));
      end
   end

   // Control and working registers.
   msat_pkg::state_type state_ff, state_in;
   msat_pkg::mode_type  mode_ff, mode_in;
   msat_pkg::op_type    pend_op_ff, pend_op_in;
   logic                pend_v_ff, pend_v_in;
   logic [SID_W-1:0]    pend_sid_ff, pend_sid_in;
   logic [SID_W-1:0]    cnt_ff, cnt_in;
   logic [2:0]          func_ff, func_in;
   logic [2:0]          sess_ff, sess_in;
   logic [63:0]         now_ff, now_in;
   logic [63:0]         once_ff, once_in;
   logic [63:0]         per_ff, per_in;
   logic [63:0]         acc_t_ff, acc_t_in;
   logic [SID_W-1:0]    acc_sid_ff, acc_sid_in;
   logic                found_ff, found_in;
   logic [63:0]         end_ff, end_in;
   logic [63:0]         wake_ff, wake_in;
   logic [N_W-1:0]      n_ff, n_in;
   logic                held_v_ff, held_v_in;
   logic [SID_W-1:0]    held_sid_ff, held_sid_in;

   // Result register.
   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  kind_ff, kind_in;
   logic [2:0]  rsess_ff, rsess_in;
   logic [63:0] rval_ff, rval_in;
   logic        rlast_ff, rlast_in;

   logic        out_free, accept, div_start, div_done, head_hit;
   logic [63:0] div_q, once_dly, per_len;
   logic [64:0] end_sum;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign accept   = req_valid && !req_stall;
   assign shift    = (state_ff == msat_pkg::ST_PASS);
   assign end_sum  = {1'b0, acc_t_ff} + 65'(cluster_ff);

   // Clamped delay and period of an arm request.
   always_comb begin
      once_dly = (req_value_us < 64'(min_once_ff)) ? 64'(min_once_ff) : req_value_us;
      if (req_value_us == 64'd0) begin
         per_len = '0;
      end else begin
         per_len = (req_value_us < 64'(min_per_ff)) ? 64'(min_per_ff) : req_value_us;
      end
   end

   // Pending update of the entry at the head of the ring.
   always_comb begin
      head_mod = ent_q[0];
      head_hit = pend_v_ff && (sid_q[0] == pend_sid_ff);
      if (head_hit) begin
         case (pend_op_ff)
            msat_pkg::OP_ONCE: begin
               head_mod.period = '0;
               head_mod.atime  = now_ff + once_ff;
               head_mod.armed  = 1'b1;
            end
            msat_pkg::OP_PERIODIC: begin
               head_mod.period = per_ff;
               head_mod.atime  = now_ff + per_ff;
               head_mod.armed  = (per_ff != 64'd0);
            end
            msat_pkg::OP_OPEN: begin
               head_mod.open   = now_ff;
               head_mod.period = '0;
               head_mod.armed  = 1'b0;
            end
            msat_pkg::OP_FIRE: begin
               if (ent_q[0].period != 64'd0) begin
                  head_mod.atime = ent_q[0].atime + ent_q[0].period;
               end else begin
                  head_mod.armed = 1'b0;
               end
            end
            default: ;
         endcase
      end
   end

   // Sequencer: next state, pass accumulation and result writes.
   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      pend_op_in   = pend_op_ff;
      pend_v_in    = pend_v_ff;
      pend_sid_in  = pend_sid_ff;
      cnt_in       = cnt_ff;
      func_in      = func_ff;
      sess_in      = sess_ff;
      now_in       = now_ff;
      once_in      = once_ff;
      per_in       = per_ff;
      acc_t_in     = acc_t_ff;
      acc_sid_in   = acc_sid_ff;
      found_in     = found_ff;
      end_in       = end_ff;
      wake_in      = wake_ff;
      n_in         = n_ff;
      held_v_in    = held_v_ff;
      held_sid_in  = held_sid_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      kind_in      = kind_ff;
      rsess_in     = rsess_ff;
      rval_in      = rval_ff;
      rlast_in     = rlast_ff;
      div_start    = 1'b0;

      case (state_ff)
         msat_pkg::ST_IDLE: begin
            if (accept) begin
               func_in     = req_func;
               sess_in     = req_session;
               now_in      = req_now_us;
               once_in     = once_dly;
               per_in      = per_len;
               pend_sid_in = SID_W'(req_session);
               cnt_in      = '0;
               found_in    = 1'b0;
               if (req_func == msat_pkg::FN_TICK) begin
                  if (req_now_us >= wake_ff) begin
                     n_in      = '0;
                     held_v_in = 1'b0;
                     pend_v_in = 1'b0;
                     mode_in   = msat_pkg::MODE_DUE;
                     state_in  = msat_pkg::ST_PASS;
                  end
               end else if (7'(req_session) < 7'(SESSIONS)) begin
                  case (req_func)
                     msat_pkg::FN_ONCE: begin
                        pend_op_in = msat_pkg::OP_ONCE;
                        pend_v_in  = 1'b1;
                        mode_in    = msat_pkg::MODE_SOON;
                        state_in   = msat_pkg::ST_PASS;
                     end
                     msat_pkg::FN_PERIODIC: begin
                        pend_op_in = msat_pkg::OP_PERIODIC;
                        pend_v_in  = 1'b1;
                        mode_in    = msat_pkg::MODE_SOON;
                        state_in   = (per_len != 64'd0) ? msat_pkg::ST_PER_OUT
                                                        : msat_pkg::ST_PASS;
                     end
                     msat_pkg::FN_READ_US, msat_pkg::FN_READ_MS: begin
                        pend_v_in = 1'b0;
                        mode_in   = msat_pkg::MODE_READ;
                        state_in  = msat_pkg::ST_PASS;
                     end
                     msat_pkg::FN_OPEN: begin
                        pend_op_in = msat_pkg::OP_OPEN;
                        pend_v_in  = 1'b1;
                        mode_in    = msat_pkg::MODE_SOON;
                        state_in   = msat_pkg::ST_PASS;
                     end
                     default: ;
                  endcase
               end
            end
         end

         // Immediate fire of a periodic arm.
         msat_pkg::ST_PER_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               kind_in      = msat_pkg::KIND_FIRE;
               rsess_in     = sess_ff;
               rval_in      = '0;
               rlast_in     = 1'b1;
               state_in     = msat_pkg::ST_PASS;
            end
         end

         // One head entry per cycle; the ring is back in its home order at the end of the pass.
         msat_pkg::ST_PASS: begin
            case (mode_ff)
               msat_pkg::MODE_SOON: begin
                  if (head_mod.armed && (!found_ff || head_mod.atime < acc_t_ff)) begin
                     acc_t_in = head_mod.atime;
                     found_in = 1'b1;
                  end
               end
               msat_pkg::MODE_RES: begin
                  if (head_mod.armed && head_mod.atime <= end_ff &&
                      head_mod.atime > acc_t_ff) begin
                     acc_t_in = head_mod.atime;
                  end
               end
               msat_pkg::MODE_DUE: begin
                  if (head_mod.armed && head_mod.atime <= now_ff &&
                      (!found_ff || head_mod.atime < acc_t_ff ||
                       (head_mod.atime == acc_t_ff && sid_q[0] < acc_sid_ff))) begin
                     acc_t_in   = head_mod.atime;
                     acc_sid_in = sid_q[0];
                     found_in   = 1'b1;
                  end
               end
               default: begin
                  if (7'(sid_q[0]) == 7'(sess_ff)) begin
                     acc_t_in = head_mod.open;
                  end
               end
            endcase
            cnt_in = cnt_ff + SID_W'(1);
            if (cnt_ff == SID_W'(SESSIONS - 1)) begin
               cnt_in    = '0;
               pend_v_in = 1'b0;
               state_in  = msat_pkg::ST_POST;
            end
         end

         // Decisions taken once a pass is complete.
         msat_pkg::ST_POST: begin
            case (mode_ff)
               msat_pkg::MODE_SOON: begin
                  if (!found_ff) begin
                     wake_in  = msat_pkg::TIME_INFINITE;
                     state_in = msat_pkg::ST_IDLE;
                  end else begin
                     end_in   = end_sum[64] ? msat_pkg::TIME_INFINITE : end_sum[63:0];
                     mode_in  = msat_pkg::MODE_RES;
                     state_in = msat_pkg::ST_PASS;
                  end
               end
               msat_pkg::MODE_RES: begin
                  wake_in  = acc_t_ff;
                  state_in = msat_pkg::ST_IDLE;
               end
               msat_pkg::MODE_DUE: begin
                  if (!found_ff) begin
                     state_in = msat_pkg::ST_FLUSH;
                  end else if (!held_v_ff || out_free) begin
                     if (held_v_ff) begin
                        rsp_valid_in = 1'b1;
                        kind_in      = msat_pkg::KIND_FIRE;
                        rsess_in     = 3'(held_sid_ff);
                        rval_in      = '0;
                        rlast_in     = 1'b0;
                     end
                     held_v_in   = 1'b1;
                     held_sid_in = acc_sid_ff;
                     pend_v_in   = 1'b1;
                     pend_op_in  = msat_pkg::OP_FIRE;
                     pend_sid_in = acc_sid_ff;
                     n_in        = n_ff + N_W'(1);
                     found_in    = 1'b0;
                     state_in    = (n_ff == N_W'(MAX_FIRES - 1)) ? msat_pkg::ST_FLUSH
                                                                 : msat_pkg::ST_PASS;
                  end
               end
               default: begin
                  if (func_ff == msat_pkg::FN_READ_MS) begin
                     div_start = 1'b1;
                     state_in  = msat_pkg::ST_DIV;
                  end else if (out_free) begin
                     rsp_valid_in = 1'b1;
                     kind_in      = msat_pkg::KIND_US;
                     rsess_in     = sess_ff;
                     rval_in      = now_ff - acc_t_ff;
                     rlast_in     = 1'b1;
                     state_in     = msat_pkg::ST_IDLE;
                  end
               end
            endcase
         end

         // Final fire of a tick, then the deadline passes.
         msat_pkg::ST_FLUSH: begin
            if (!held_v_ff || out_free) begin
               if (held_v_ff) begin
                  rsp_valid_in = 1'b1;
                  kind_in      = msat_pkg::KIND_FIRE;
                  rsess_in     = 3'(held_sid_ff);
                  rval_in      = '0;
                  rlast_in     = 1'b1;
               end
               held_v_in = 1'b0;
               found_in  = 1'b0;
               mode_in   = msat_pkg::MODE_SOON;
               state_in  = msat_pkg::ST_PASS;
            end
         end

         msat_pkg::ST_DIV: begin
            if (div_done && out_free) begin
               rsp_valid_in = 1'b1;
               kind_in      = msat_pkg::KIND_MS;
               rsess_in     = sess_ff;
               rval_in      = div_q;
               rlast_in     = 1'b1;
               state_in     = msat_pkg::ST_IDLE;
            end
         end

         default: state_in = msat_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= msat_pkg::ST_IDLE;
         mode_ff      <= msat_pkg::MODE_SOON;
         pend_op_ff   <= msat_pkg::OP_NONE;
         pend_v_ff    <= 1'b0;
         cnt_ff       <= '0;
         found_ff     <= 1'b0;
         wake_ff      <= msat_pkg::TIME_INFINITE;
         n_ff         <= '0;
         held_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         pend_op_ff   <= pend_op_in;
         pend_v_ff    <= pend_v_in;
         cnt_ff       <= cnt_in;
         found_ff     <= found_in;
         wake_ff      <= wake_in;
         n_ff         <= n_in;
         held_v_ff    <= held_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      pend_sid_ff <= pend_sid_in;
      func_ff     <= func_in;
      sess_ff     <= sess_in;
      now_ff      <= now_in;
      once_ff     <= once_in;
      per_ff      <= per_in;
      acc_t_ff    <= acc_t_in;
      acc_sid_ff  <= acc_sid_in;
      end_ff      <= end_in;
      held_sid_ff <= held_sid_in;
      kind_ff     <= kind_in;
      rsess_ff    <= rsess_in;
      rval_ff     <= rval_in;
      rlast_ff    <= rlast_in;
   end

   msat_div u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .dividend(now_ff - acc_t_ff), .done(div_done), .quotient(div_q));

   assign req_stall       = (state_ff != msat_pkg::ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = kind_ff;
   assign rsp_session_res = rsess_ff;
   assign rsp_value       = rval_ff;
   assign rsp_last        = rlast_ff;

   // The ring is back in its home order whenever no pass is running.
   a_ring_home: assert property (@(posedge clock) disable iff (reset)
      (state_ff == msat_pkg::ST_IDLE) |-> (sid_q[0] == '0))
      else $error("ring not in home order while idle");

   // A tick never fires more alarms than allowed.
   a_fire_cap: assert property (@(posedge clock) disable iff (reset)
      n_ff <= N_W'(MAX_FIRES))
      else $error("fire count above limit");

   // A new request is only taken once the last result has been handed over
   // or is sitting in the output register.
   a_no_held_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == msat_pkg::ST_IDLE) |-> !held_v_ff && !pend_v_ff)
      else $error("leftover fire or update while idle");

endmodule

`default_nettype wire

[tb/tb.sv]
// Self-checking testbench for the multi-session alarm timer.
`default_nettype none

module tb;

   // One result transaction as seen on the result channel.
   typedef struct packed {
      logic [1:0]  kind;
      logic [2:0]  session;
      logic [63:0] value;
      logic        last;
   } timer_result_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [2:0]  req_func;
   logic [2:0]  req_session;
   logic [63:0] req_value_us;
   logic [63:0] req_now_us;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [1:0]  rsp_kind;
   logic [2:0]  rsp_session_res;
   logic [63:0] rsp_value;
   logic        rsp_last;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [19:0] csr_wdata;

   multi_session_alarm_timer u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_func(req_func),
      .req_session(req_session), .req_value_us(req_value_us), .req_now_us(req_now_us),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_kind(rsp_kind),
      .rsp_session_res(rsp_session_res), .rsp_value(rsp_value), .rsp_last(rsp_last),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // Predicted timer state and configuration.
   logic [15:0] cluster_window;
   logic [15:0] min_oneshot;
   logic [19:0] min_period;
   logic [63:0] alarm_at [8];
   logic        alarm_on [8];
   logic [63:0] period_of [8];
   logic [63:0] opened_at [8];
   logic [63:0] wake_at;

   timer_result_type pending_results[$];
   int          mismatches = 0;
   int          hold_left;
   logic        hold_go;
   int          stall_burst;
   bit          quiet;
   logic [63:0] now_t;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Recompute the wakeup deadline: latest alarm inside the cluster window.
   function automatic void refresh_wake();
      bit          found;
      logic [63:0] soon;
      logic [63:0] win_end;
      logic [63:0] res;
      found = 0;
      soon = '0;
      for (int s = 0; s < 8; s++)
         if (alarm_on[s] && (!found || alarm_at[s] < soon)) begin
            soon = alarm_at[s];
            found = 1;
         end
      if (!found) begin
         wake_at = msat_pkg::TIME_INFINITE;
         return;
      end
      win_end = soon + 64'(cluster_window);
      if (win_end < soon) win_end = msat_pkg::TIME_INFINITE;
      res = soon;
      for (int s = 0; s < 8; s++)
         if (alarm_on[s] && alarm_at[s] <= win_end && alarm_at[s] > res) res = alarm_at[s];
      wake_at = res;
   endfunction

   // Apply one request to the predicted state and queue the results it causes.
   function automatic void predict_timer(logic [2:0] func, logic [2:0] sess,
                                         logic [63:0] val, logic [63:0] now);
      timer_result_type fires[$];
      timer_result_type r;
      int               d;
      logic [63:0]      v;
      case (func)
         msat_pkg::FN_TICK: begin
            if (now < wake_at) return;
            while (fires.size() < 64) begin
               d = -1;
               for (int s = 0; s < 8; s++)
                  if (alarm_on[s] && alarm_at[s] <= now && (d < 0 || alarm_at[s] < alarm_at[d]))
                     d = s;
               if (d < 0) break;
               r = '{kind: msat_pkg::KIND_FIRE, session: 3'(d), value: '0, last: 1'b0};
               fires.push_back(r);
               if (period_of[d] != 0) alarm_at[d] += period_of[d];
               else alarm_on[d] = 0;
            end
            refresh_wake();
            if (fires.size() > 0) fires[fires.size()-1].last = 1'b1;
            foreach (fires[i]) pending_results.push_back(fires[i]);
         end
         msat_pkg::FN_ONCE: begin
            period_of[sess] = '0;
            v = (val < 64'(min_oneshot)) ? 64'(min_oneshot) : val;
            alarm_at[sess] = now + v;
            alarm_on[sess] = 1;
            refresh_wake();
         end
         msat_pkg::FN_PERIODIC: begin
            period_of[sess] = '0;
            alarm_on[sess] = 0;
            if (val != 0) begin
               v = (val < 64'(min_period)) ? 64'(min_period) : val;
               period_of[sess] = v;
               pending_results.push_back('{kind: msat_pkg::KIND_FIRE, session: sess,
                                           value: '0, last: 1'b1});
               alarm_at[sess] = now + v;
               alarm_on[sess] = 1;
            end
            refresh_wake();
         end
         msat_pkg::FN_READ_US:
            pending_results.push_back('{kind: msat_pkg::KIND_US, session: sess,
                                        value: now - opened_at[sess], last: 1'b1});
         msat_pkg::FN_READ_MS:
            pending_results.push_back('{kind: msat_pkg::KIND_MS, session: sess,
                                        value: (now - opened_at[sess]) / 64'd1000, last: 1'b1});
         msat_pkg::FN_OPEN: begin
            opened_at[sess] = now;
            alarm_on[sess] = 0;
            period_of[sess] = '0;
            refresh_wake();
         end
         default: ;
      endcase
   endfunction

   // Send one request transaction, with an occasional idle burst ahead of it.
   task automatic send_request(logic [2:0] func, logic [2:0] sess,
                               logic [63:0] val, logic [63:0] now);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      predict_timer(func, sess, val, now);
      req_valid    <= 1'b1;
      req_func     <= func;
      req_session  <= sess;
      req_value_us <= val;
      req_now_us   <= now;
      do @(posedge clock); while (req_stall);
   endtask

   // Let all expected results drain and the block settle.
   task automatic wait_idle();
      req_valid <= 1'b0;
      wait (pending_results.size() == 0);
      repeat (200) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [19:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         msat_pkg::CSR_CLUSTER:  cluster_window = data[15:0];
         msat_pkg::CSR_MIN_ONCE: min_oneshot = data[15:0];
         msat_pkg::CSR_MIN_PER:  min_period = data;
         default: ;
      endcase
   endtask

   task automatic set_config(logic [19:0] win, logic [19:0] once, logic [19:0] per);
      wait_idle();
      write_csr(msat_pkg::CSR_CLUSTER, win);
      write_csr(msat_pkg::CSR_MIN_ONCE, once);
      write_csr(msat_pkg::CSR_MIN_PER, per);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // Reads, opens, ignored codes and the corner values of time.
   task automatic test_reads_and_opens();
      send_request(msat_pkg::FN_READ_US, 3'd0, 64'd0, 64'd0);
      send_request(msat_pkg::FN_READ_MS, 3'd7, '1, '1);
      send_request(msat_pkg::FN_OPEN, 3'd7, 64'd5, 64'd123456);
      send_request(msat_pkg::FN_READ_US, 3'd7, 64'd0, 64'd100);
      send_request(msat_pkg::FN_READ_MS, 3'd7, 64'd0, 64'd9_999_999);
      send_request(3'd6, 3'd2, '1, 64'd7);
      send_request(3'd7, 3'd5, 64'd0, '1);
      send_request(msat_pkg::FN_TICK, 3'd0, 64'd0, '1);
   endtask

   // One-shot and periodic arms, disarm, and ticks before and at the deadline.
   task automatic test_arms_and_ticks();
      send_request(msat_pkg::FN_ONCE, 3'd0, 64'd0, 64'd1000);
      send_request(msat_pkg::FN_ONCE, 3'd1, 64'd300, 64'd1000);
      send_request(msat_pkg::FN_TICK, 3'd0, 64'd0, 64'd1100);
      send_request(msat_pkg::FN_TICK, 3'd4, 64'd0, 64'd1300);
      send_request(msat_pkg::FN_PERIODIC, 3'd2, 64'd10, 64'd2000);
      send_request(msat_pkg::FN_PERIODIC, 3'd3, 64'd0, 64'd2000);
      send_request(msat_pkg::FN_TICK, 3'd0, 64'd0, 64'd5500);
      send_request(msat_pkg::FN_ONCE, 3'd4, '1, 64'd6000);
      send_request(msat_pkg::FN_TICK, 3'd0, 64'd0, 64'd6001);
      send_request(msat_pkg::FN_PERIODIC, 3'd5, '1, 64'd10);
      send_request(msat_pkg::FN_TICK, 3'd0, '1, 64'd20);
      send_request(msat_pkg::FN_OPEN, 3'd2, 64'd0, 64'd9000);
      send_request(msat_pkg::FN_OPEN, 3'd5, 64'd0, 64'd9000);
   endtask

   // A short period far behind the clock fires the per-tick maximum.
   task automatic test_fire_limit();
      set_config(20'd0, 20'd0, 20'd1);
      send_request(msat_pkg::FN_PERIODIC, 3'd3, 64'd1, 64'd0);
      send_request(msat_pkg::FN_PERIODIC, 3'd6, 64'd1, 64'd30);
      send_request(msat_pkg::FN_TICK, 3'd0, 64'd0, 64'd500);
      send_request(msat_pkg::FN_TICK, 3'd0, 64'd0, 64'd500);
      send_request(msat_pkg::FN_OPEN, 3'd3, 64'd0, 64'd600);
      send_request(msat_pkg::FN_OPEN, 3'd6, 64'd0, 64'd600);
   endtask

   // Random items with a time base that mostly moves forward.
   task automatic test_random(int count);
      int          r;
      int          r2;
      logic [63:0] v;
      repeat (count) begin
         r = $urandom_range(0, 99);
         r2 = $urandom_range(0, 99);
         now_t += 64'($urandom_range(0, 50));
         if (r < 35) begin
            now_t += 64'($urandom_range(0, 3000));
            send_request(msat_pkg::FN_TICK, 3'($urandom), rand64(), now_t);
         end else if (r < 55) begin
            v = (r2 < 10) ? rand64() : 64'($urandom_range(0, 2000));
            send_request(msat_pkg::FN_ONCE, 3'($urandom), v, now_t);
         end else if (r < 70) begin
            v = (r2 < 10) ? 64'd0 : (r2 < 20) ? rand64() : 64'($urandom_range(0, 3000));
            send_request(msat_pkg::FN_PERIODIC, 3'($urandom), v, now_t);
         end else if (r < 80) begin
            send_request(msat_pkg::FN_READ_US, 3'($urandom), rand64(), now_t);
         end else if (r < 88) begin
            send_request(msat_pkg::FN_READ_MS, 3'($urandom), rand64(), now_t);
         end else if (r < 95) begin
            send_request(msat_pkg::FN_OPEN, 3'($urandom), rand64(), now_t);
         end else if (r2 < 50) begin
            send_request(3'($urandom_range(6, 7)), 3'($urandom), rand64(), rand64());
         end else begin
            // A jump of the time base anywhere in its range.
            now_t = rand64();
            send_request(3'($urandom_range(0, 5)), 3'($urandom), rand64(), now_t);
         end
      end
   endtask

   // Each register setting, extremes included, with some traffic under it.
   task automatic test_config_sweep();
      set_config(20'd0, 20'd0, 20'd1);
      test_random(12);
      set_config(20'hFFFFF, 20'hFFFFF, 20'hFFFFF);
      test_random(12);
      set_config(20'd5000, 20'd1, 20'd50);
      test_random(12);
      set_config(20'(msat_pkg::CLUSTER_RESET), 20'(msat_pkg::MIN_ONCE_RESET),
                 20'(msat_pkg::MIN_PER_RESET));
   endtask

   // The receiver holds off long enough for the block to stall its input.
   task automatic test_backpressure();
      wait_idle();
      hold_go <= 1'b1;
      @(posedge clock);
      hold_go <= 1'b0;
      for (int i = 0; i < 10; i++)
         send_request(msat_pkg::FN_READ_US, 3'(i), 64'd0, now_t + 64'(i));
      send_request(msat_pkg::FN_PERIODIC, 3'd1, 64'd2000, now_t);
   endtask

   // Long receiver hold-off, counted down in cycles.
   always @(posedge clock) begin
      if (reset) hold_left <= 0;
      else if (hold_go) hold_left <= 400;
      else if (hold_left > 0) hold_left <= hold_left - 1;
   end

   // Receiver stall: long hold-off when asked, otherwise random short bursts.
   always @(posedge clock) begin
      if (reset || quiet) begin
         rsp_stall <= 1'b0;
         stall_burst <= 0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
      end else if (stall_burst > 0) begin
         rsp_stall <= 1'b1;
         stall_burst <= stall_burst - 1;
      end else if ($urandom_range(0, 5) == 0) begin
         rsp_stall <= 1'b1;
         stall_burst <= $urandom_range(0, 2);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Compare each accepted result transaction with the oldest expectation.
   always @(posedge clock) begin
      timer_result_type got;
      timer_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{kind: rsp_kind, session: rsp_session_res, value: rsp_value, last: rsp_last};
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result kind=%0d session=%0d value=%0h last=%0b",
                        got.kind, got.session, got.value, got.last);
         end else begin
            want = pending_results.pop_front();
            if (got != want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected kind=%0d session=%0d value=%0h last=%0b, %s",
                           want.kind, want.session, want.value, want.last,
                           $sformatf("got kind=%0d session=%0d value=%0h last=%0b",
                                     got.kind, got.session, got.value, got.last));
            end
         end
      end
   end

   // Stimulus sequence.
   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_func = msat_pkg::FN_TICK;
      req_session = '0;
      req_value_us = '0;
      req_now_us = '0;
      csr_we = 1'b0;
      csr_index = msat_pkg::CSR_CLUSTER;
      csr_wdata = '0;
      hold_go = 1'b0;
      quiet = 0;
      now_t = 64'd20000;
      cluster_window = msat_pkg::CLUSTER_RESET;
      min_oneshot = msat_pkg::MIN_ONCE_RESET;
      min_period = msat_pkg::MIN_PER_RESET;
      for (int s = 0; s < 8; s++) begin
         alarm_at[s] = '0;
         alarm_on[s] = 0;
         period_of[s] = '0;
         opened_at[s] = '0;
      end
      wake_at = msat_pkg::TIME_INFINITE;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reads_and_opens();
      test_arms_and_ticks();
      test_fire_limit();
      test_config_sweep();
      test_backpressure();
      test_random(40);
      quiet = 1;
      test_random(25);

      wait_idle();
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

   // Run limit.
   initial begin
      #2000000;
      $display("tb failed");
      $finish;
   end

endmodule

`default_nettype wire
